FILE: sv/csp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Classed send slot pool package
// Shared field widths, command, class, status and register codes, the
// transaction payload types and the slot class rule.
// ----------------------------------------------------------------------------
package csp_pkg;

    // Field widths of the command and response transactions.
    localparam int CMD_W      = 2;
    localparam int PEER_W     = 4;
    localparam int CLASS_W    = 2;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 3;

    // Stored slot numbers can reach the largest slot count minus one.
    localparam int SLOT_VAL_W = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_PEER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID        = 2'd2;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Slot classes.
    localparam logic [CLASS_W-1:0] CLS_CONTROL = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_SEARCH  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_UPDATE  = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_PEER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [PEER_W-1:0]  peer;
        logic [CLASS_W-1:0] req_class;
        logic [SLOT_W-1:0]  slot_in;
    } t_cmd_item;

    typedef struct packed {
        logic                granted;
        logic [SLOT_W-1:0]   slot_out;
        logic [STATUS_W-1:0] status;
    } t_rsp_item;

    // With one slot or fewer every slot is control; otherwise even slots are
    // search and odd slots are update.
    function automatic logic [CLASS_W-1:0] class_of(input logic                  single,
                                                    input logic [SLOT_VAL_W-1:0] slot);
        logic [CLASS_W-1:0] cls;
        if (single) begin
            cls = CLS_CONTROL;
        end else if (slot[0]) begin
            cls = CLS_UPDATE;
        end else begin
            cls = CLS_SEARCH;
        end
        return cls;
    endfunction

endpackage
`default_nettype wire

FILE: sv/csp_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload per transaction; a transaction completes at a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface csp_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/csp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered read.
// The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module csp_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AddrW-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AddrW-1:0] i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/classed_send_slot_pool_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Classed send slot pool core
// Per-peer FIFO free lists of send slots, one per class, kept as ring
// buffers in a slot store memory with head and count in a list memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                 Handshake
//  i_cmd     in         command, peer, req_class, slot_in       valid/ready
//  o_rsp     out        granted, slot_out, status               valid/ready
//  i_cfg_*   in         register index, write data              write enable
//
//  Release reads the list memory and then writes the slot store; acquire
//  reads the list memory and then the slot store, with one more list
//  memory read when a control request falls back from the search list to
//  the update list. Bad peer, bad slot, unused class and unused command
//  answer straight from the decode of the command. Init rewrites the head
//  and count of every list, then writes every slot of each peer that owns
//  slots into the slot store.
//  After reset a clearing pass empties every list; no command is taken
//  until it ends.
//  A result waiting in the output register stalls the block only when the
//  next result is ready to be loaded.
// ----------------------------------------------------------------------------
module classed_send_slot_pool_core
    import csp_pkg::*;
#(
    parameter int MAX_PEERS = 16,
    parameter int MAX_SLOTS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    csp_chan_if.sink                   i_cmd,
    csp_chan_if.source                 o_rsp
);

    localparam int NumLists   = 3 * MAX_PEERS;
    localparam int ListW      = $clog2(NumLists);
    localparam int PeerW      = $clog2(MAX_PEERS);
    localparam int HeadW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CntW       = $clog2(MAX_SLOTS + 1);
    localparam int SumW       = CntW + 1;
    localparam int StoreDepth = NumLists * MAX_SLOTS;
    localparam int AddrW      = $clog2(StoreDepth);
    localparam int PeerCmpW   = ($clog2(MAX_PEERS + 1) > 5) ? $clog2(MAX_PEERS + 1) : 5;
    localparam int SlotCap    = (MAX_SLOTS > 127) ? 127 : MAX_SLOTS;
    localparam int MetaW      = HeadW + CntW;

    typedef struct packed {
        logic [HeadW-1:0] head;
        logic [CntW-1:0]  cnt;
    } t_meta;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META_SWEEP,
        S_STORE_SWEEP,
        S_META,
        S_DATA,
        S_DONE
    } t_state;

    // List index of a (peer, class) pair: peer * 3 + class.
    function automatic logic [ListW-1:0] list_idx(input logic [PeerW-1:0]   p,
                                                  input logic [CLASS_W-1:0] c);
        logic [ListW-1:0] pe;
        pe = ListW'(p);
        return (pe << 1) + pe + ListW'(c);
    endfunction

    // Slot store address of ring position pos in list li.
    function automatic logic [AddrW-1:0] store_addr(input logic [ListW-1:0] li,
                                                    input logic [HeadW-1:0] pos);
        return AddrW'(li) * AddrW'(MAX_SLOTS) + AddrW'(pos);
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [6:0] r_slots_per_peer;
    logic [4:0] r_peer_count;
    logic [3:0] r_self_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_per_peer <= 7'd1;
            r_peer_count     <= 5'd1;
            r_self_id        <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLOTS_PER_PEER: r_slots_per_peer <= i_cfg_wdata;
                CFG_PEER_COUNT:     r_peer_count     <= i_cfg_wdata[4:0];
                CFG_SELF_ID:        r_self_id        <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Effective counts and input checks
    // ------------------------------------------------------------------------
    logic [6:0]            eff_slots;
    logic [PeerCmpW-1:0]   eff_peers;
    logic                  single;
    t_cmd_item             cmd;
    logic                  cmd_acc;
    logic                  in_peer_ok;
    logic                  in_peer_self;
    logic                  in_slot_ok;
    logic                  acq_bad_cls;
    logic [CLASS_W-1:0]    acq_cls;
    logic [CLASS_W-1:0]    in_cls;
    logic [ListW-1:0]      in_list;

    assign eff_slots = (r_slots_per_peer > 7'(SlotCap)) ? 7'(SlotCap) : r_slots_per_peer;
    assign eff_peers = (PeerCmpW'(r_peer_count) > PeerCmpW'(MAX_PEERS)) ?
                       PeerCmpW'(MAX_PEERS) : PeerCmpW'(r_peer_count);
    assign single    = (eff_slots <= 7'd1);

    assign cmd          = i_cmd.payload;
    assign cmd_acc      = i_cmd.valid && i_cmd.ready;
    assign in_peer_ok   = (PeerCmpW'(cmd.peer) < eff_peers);
    assign in_peer_self = (cmd.peer == r_self_id);
    assign in_slot_ok   = (7'(cmd.slot_in) < eff_slots);

    // Acquire list: one slot per peer always uses control; a control request
    // starts with search and may fall back to update.
    assign acq_bad_cls = (eff_slots != 7'd1) && (cmd.req_class > CLS_UPDATE);
    assign acq_cls     = (eff_slots == 7'd1)            ? CLS_CONTROL :
                         (cmd.req_class == CLS_CONTROL) ? CLS_SEARCH  : cmd.req_class;
    assign in_cls      = (cmd.command == CMD_ACQUIRE) ? acq_cls :
                         class_of(single, SLOT_VAL_W'(cmd.slot_in));
    assign in_list     = list_idx(PeerW'(cmd.peer), in_cls);

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    logic                  meta_wr_en;
    logic [ListW-1:0]      meta_wr_addr;
    t_meta                 meta_wr_data;
    logic                  meta_rd_en;
    logic [ListW-1:0]      meta_rd_addr;
    t_meta                 meta_rd_data;

    logic                  store_wr_en;
    logic [AddrW-1:0]      store_wr_addr;
    logic [SLOT_VAL_W-1:0] store_wr_data;
    logic                  store_rd_en;
    logic [AddrW-1:0]      store_rd_addr;
    logic [SLOT_VAL_W-1:0] store_rd_data;

    csp_ram #(
        .DEPTH (NumLists),
        .WIDTH (MetaW)
    ) u_list_mem (
        .i_clk     (i_clk),
        .i_wr_en   (meta_wr_en),
        .i_wr_addr (meta_wr_addr),
        .i_wr_data (meta_wr_data),
        .i_rd_en   (meta_rd_en),
        .i_rd_addr (meta_rd_addr),
        .o_rd_data (meta_rd_data)
    );

    csp_ram #(
        .DEPTH (StoreDepth),
        .WIDTH (SLOT_VAL_W)
    ) u_slot_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr_en),
        .i_wr_addr (store_wr_addr),
        .i_wr_data (store_wr_data),
        .i_rd_en   (store_rd_en),
        .i_rd_addr (store_rd_addr),
        .o_rd_data (store_rd_data)
    );

    // ------------------------------------------------------------------------
    // Control registers and their next values
    // ------------------------------------------------------------------------
    t_state                r_state,     n_state;
    logic                  r_clr,       n_clr;
    logic [ListW-1:0]      r_sw_list,   n_sw_list;
    logic [PeerW-1:0]      r_sw_peer,   n_sw_peer;
    logic [CLASS_W-1:0]    r_sw_cls,    n_sw_cls;
    logic [SLOT_VAL_W-1:0] r_sw_slot,   n_sw_slot;
    logic                  r_try_upd,   n_try_upd;
    logic                  r_out_vld,   n_out_vld;
    logic [CMD_W-1:0]      r_op,        n_op;
    logic [ListW-1:0]      r_list,      n_list;
    logic [SLOT_VAL_W-1:0] r_slot,      n_slot;
    t_rsp_item             r_res,       n_res;
    t_rsp_item             r_out,       n_out;

    logic                  fin;
    t_rsp_item             fin_res;
    logic                  out_free;
    logic                  out_load;

    // Sweep helpers.
    logic                  sw_peer_act;
    logic [7:0]            sweep_raw;
    logic [CntW-1:0]       sweep_cnt;
    logic [HeadW-1:0]      sw_pos;

    // Ring arithmetic on the list that was read.
    logic [SumW-1:0]       tail_sum;
    logic [HeadW-1:0]      tail_pos;
    logic [HeadW-1:0]      head_inc;

    assign sw_peer_act = (PeerCmpW'(r_sw_peer) < eff_peers) &&
                         (PeerCmpW'(r_sw_peer) != PeerCmpW'(r_self_id));

    always_comb begin
        case (r_sw_cls)
            CLS_CONTROL: sweep_raw = single ? {1'b0, eff_slots} : 8'd0;
            CLS_SEARCH:  sweep_raw = single ? 8'd0 : ({1'b0, eff_slots} + 8'd1) >> 1;
            default:     sweep_raw = single ? 8'd0 : {1'b0, eff_slots} >> 1;
        endcase
    end

    assign sweep_cnt = (sw_peer_act && !r_clr) ? CntW'(sweep_raw) : '0;
    assign sw_pos    = single ? '0 : HeadW'(r_sw_slot >> 1);

    assign tail_sum = SumW'(meta_rd_data.head) + SumW'(meta_rd_data.cnt);
    assign tail_pos = (tail_sum >= SumW'(MAX_SLOTS)) ?
                      HeadW'(tail_sum - SumW'(MAX_SLOTS)) : HeadW'(tail_sum);
    assign head_inc = (meta_rd_data.head == HeadW'(MAX_SLOTS - 1)) ?
                      '0 : meta_rd_data.head + 1'b1;

    assign out_free = !r_out_vld || o_rsp.ready;

    // ------------------------------------------------------------------------
    // Sequencer: sweeps, list read, slot store access and result hand-off
    // ------------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_sw_list = r_sw_list;
        n_sw_peer = r_sw_peer;
        n_sw_cls  = r_sw_cls;
        n_sw_slot = r_sw_slot;
        n_try_upd = r_try_upd;
        n_op      = r_op;
        n_list    = r_list;
        n_slot    = r_slot;
        fin       = 1'b0;
        fin_res   = '0;

        meta_wr_en    = 1'b0;
        meta_wr_addr  = '0;
        meta_wr_data  = '0;
        meta_rd_en    = 1'b0;
        meta_rd_addr  = '0;
        store_wr_en   = 1'b0;
        store_wr_addr = '0;
        store_wr_data = '0;
        store_rd_en   = 1'b0;
        store_rd_addr = '0;

        unique case (r_state)
            // Rewrite every list head and count, zero on the clearing pass.
            S_META_SWEEP: begin
                meta_wr_en       = 1'b1;
                meta_wr_addr     = r_sw_list;
                meta_wr_data.cnt = sweep_cnt;
                if (r_sw_list == ListW'(NumLists - 1)) begin
                    n_sw_peer = '0;
                    n_sw_slot = '0;
                    n_state   = r_clr ? S_IDLE : S_STORE_SWEEP;
                    n_clr     = 1'b0;
                end else begin
                    n_sw_list = r_sw_list + 1'b1;
                    if (r_sw_cls == CLS_UPDATE) begin
                        n_sw_cls  = CLS_CONTROL;
                        n_sw_peer = r_sw_peer + 1'b1;
                    end else begin
                        n_sw_cls = r_sw_cls + 1'b1;
                    end
                end
            end

            // Fill the slot store of each owning peer, one slot per cycle.
            S_STORE_SWEEP: begin
                store_wr_en   = sw_peer_act && (r_sw_slot < eff_slots);
                store_wr_addr = store_addr(list_idx(r_sw_peer, class_of(single, r_sw_slot)),
                                           sw_pos);
                store_wr_data = r_sw_slot;
                if (!sw_peer_act || ({1'b0, r_sw_slot} + 8'd1 >= {1'b0, eff_slots})) begin
                    n_sw_slot = '0;
                    if (r_sw_peer == PeerW'(MAX_PEERS - 1)) begin
                        fin = 1'b1;
                    end else begin
                        n_sw_peer = r_sw_peer + 1'b1;
                    end
                end else begin
                    n_sw_slot = r_sw_slot + 1'b1;
                end
            end

            // Decode a new command and start the list read.
            S_IDLE: begin
                if (cmd_acc) begin
                    n_op   = cmd.command;
                    n_slot = SLOT_VAL_W'(cmd.slot_in);
                    n_list = in_list;
                    unique case (cmd.command)
                        CMD_INIT: begin
                            n_state   = S_META_SWEEP;
                            n_clr     = 1'b0;
                            n_sw_list = '0;
                            n_sw_peer = '0;
                            n_sw_cls  = CLS_CONTROL;
                        end
                        CMD_ACQUIRE: begin
                            if (!in_peer_ok || in_peer_self) begin
                                fin            = 1'b1;
                                fin_res.status = ST_BAD_PEER;
                            end else if (acq_bad_cls) begin
                                fin            = 1'b1;
                                fin_res.status = ST_EMPTY;
                            end else begin
                                meta_rd_en   = 1'b1;
                                meta_rd_addr = in_list;
                                n_try_upd    = (eff_slots != 7'd1) &&
                                               (cmd.req_class == CLS_CONTROL);
                                n_state      = S_META;
                            end
                        end
                        CMD_RELEASE: begin
                            if (!in_peer_ok) begin
                                fin            = 1'b1;
                                fin_res.status = ST_BAD_PEER;
                            end else if (!in_slot_ok) begin
                                fin            = 1'b1;
                                fin_res.status = ST_BAD_SLOT;
                            end else begin
                                meta_rd_en   = 1'b1;
                                meta_rd_addr = in_list;
                                n_try_upd    = 1'b0;
                                n_state      = S_META;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // List head and count are available: pop or push.
            S_META: begin
                if (r_op == CMD_ACQUIRE) begin
                    if (meta_rd_data.cnt == '0) begin
                        if (r_try_upd) begin
                            // The update list follows the search list of the same peer.
                            meta_rd_en   = 1'b1;
                            meta_rd_addr = r_list + 1'b1;
                            n_list       = r_list + 1'b1;
                            n_try_upd    = 1'b0;
                        end else begin
                            fin            = 1'b1;
                            fin_res.status = ST_EMPTY;
                        end
                    end else begin
                        store_rd_en       = 1'b1;
                        store_rd_addr     = store_addr(r_list, meta_rd_data.head);
                        meta_wr_en        = 1'b1;
                        meta_wr_addr      = r_list;
                        meta_wr_data.head = head_inc;
                        meta_wr_data.cnt  = meta_rd_data.cnt - 1'b1;
                        n_state           = S_DATA;
                    end
                end else begin
                    if (SumW'(meta_rd_data.cnt) >= SumW'(MAX_SLOTS)) begin
                        fin            = 1'b1;
                        fin_res.status = ST_OVERFLOW;
                    end else begin
                        store_wr_en       = 1'b1;
                        store_wr_addr     = store_addr(r_list, tail_pos);
                        store_wr_data     = r_slot;
                        meta_wr_en        = 1'b1;
                        meta_wr_addr      = r_list;
                        meta_wr_data.head = meta_rd_data.head;
                        meta_wr_data.cnt  = meta_rd_data.cnt + 1'b1;
                        fin               = 1'b1;
                    end
                end
            end

            // Popped slot number is available.
            S_DATA: begin
                fin              = 1'b1;
                fin_res.granted  = 1'b1;
                fin_res.slot_out = store_rd_data[SLOT_W-1:0];
            end

            S_DONE: ;

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Result hand-off to the output register.
        n_res    = fin ? fin_res : r_res;
        out_load = 1'b0;
        n_out    = r_out;
        if (fin) begin
            if (out_free) begin
                out_load = 1'b1;
                n_out    = fin_res;
                n_state  = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end else if ((r_state == S_DONE) && out_free) begin
            out_load = 1'b1;
            n_out    = r_res;
            n_state  = S_IDLE;
        end
        n_out_vld = out_load || (r_out_vld && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_META_SWEEP;
            r_clr     <= 1'b1;
            r_sw_list <= '0;
            r_sw_peer <= '0;
            r_sw_cls  <= CLS_CONTROL;
            r_sw_slot <= '0;
            r_try_upd <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_sw_list <= n_sw_list;
            r_sw_peer <= n_sw_peer;
            r_sw_cls  <= n_sw_cls;
            r_sw_slot <= n_sw_slot;
            r_try_upd <= n_try_upd;
            r_out_vld <= n_out_vld;
        end
        r_op   <= n_op;
        r_list <= n_list;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // ------------------------------------------------------------------------
    // Channel outputs
    // ------------------------------------------------------------------------
    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A pop reads the slot store in the same cycle as it shortens the list.
    a_pop_updates_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_rd_en |-> meta_wr_en && (meta_wr_addr == r_list) &&
                        (meta_wr_data.cnt == meta_rd_data.cnt - 1'b1))
        else $error("slot pop without matching list update");

    // No list ever holds more slots than its ring.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        meta_wr_en |-> (SumW'(meta_wr_data.cnt) <= SumW'(MAX_SLOTS)))
        else $error("list count beyond ring size");

    // An accepted command either keeps the block busy or leaves a result.
    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> (r_state != S_IDLE) || r_out_vld)
        else $error("accepted command produced no result");

    // A granted slot always reports success.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.payload.granted |-> (o_rsp.payload.status == ST_OK))
        else $error("grant with error status");

endmodule
`default_nettype wire
